[design/ercd_pkg.sv]
// Package for the edge row coverage delta unit.
// Holds the fixed-point constants, the per-piece delta set type and small
// arithmetic helpers. Depends on nothing.
package ercd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TRI_SHIFT = 11;
  localparam int LOW_SHIFT = 8;
  localparam int NUM_OUT = 5;
  localparam int CNT_W = 3;
  localparam int COL_W = 32 - FRAC_BITS;

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  typedef struct packed {
    logic [NUM_OUT-1:0][31:0]      delta;
    logic [NUM_OUT-1:0][COL_W-1:0] column;
    logic [15:0]                   run2;
    logic [CNT_W-1:0]              count;
    logic                          neg;
    logic [15:0]                   row;
  } delta_set_t;

  function automatic logic [31:0] sar(input logic [31:0] v, input int unsigned n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

endpackage

[design/ercd_pipe.sv]
// Four-stage arithmetic pipeline of the edge row coverage delta unit.
// Produces the full delta set of one edge piece per cycle while adv is
// high; uses ercd_pkg. All stages advance together under adv.
module ercd_pipe
  import ercd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        start,
  input  logic [15:0] row,
  input  logic [16:0] row_height,
  input  logic [31:0] start_x,
  input  logic [31:0] end_x,
  input  logic [30:0] slope_dy,
  input  logic        winding_up,
  input  logic        partial_row,
  output logic        set_valid,
  output delta_set_t  set
);

  logic v1, v2, v3, v4;

  // Stage 1: order the end points.
  logic [31:0] l1, r1;
  logic [15:0] row1;
  logic [16:0] rh1;
  logic [30:0] dy1;
  logic        neg1, part1;

  // Stage 2: span bounds and the widths of the end columns.
  logic [COL_W-1:0] col_l2, col_r2;
  logic [16:0]      len2;
  logic [31:0]      a2, b2, alpha2;
  logic [15:0]      row2;
  logic [16:0]      rh2;
  logic [30:0]      dy2;
  logic             neg2, part2;

  // Stage 3: first products.
  logic [COL_W-1:0] col_l3, col_r3;
  logic [16:0]      len3;
  logic [31:0]      a3, sq_a3, sq_b3, fh3, run3, alpha3;
  logic [15:0]      row3;
  logic [16:0]      rh3;
  logic [30:0]      dy3;
  logic             neg3;

  // Stage 4: second products and the running sum.
  logic [COL_W-1:0] col_l4, col_r4;
  logic [16:0]      len4;
  logic [31:0]      tri_a4, tri_b4, p4, a1_4, ar2_4, alpha4;
  logic [15:0]      row4;
  logic [16:0]      rh4;
  logic [30:0]      dy4;
  logic             neg4;

  logic [16:0]      r_ceil;
  logic [31:0]      fl, fr;
  logic [15:0]      mids3;
  logic [31:0]      dy_w3, dy11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if ($signed(start_x) < $signed(end_x)) begin
        l1 <= start_x;
        r1 <= end_x;
      end else begin
        l1 <= end_x;
        r1 <= start_x;
      end
      row1  <= row;
      rh1   <= row_height;
      dy1   <= slope_dy;
      neg1  <= ~winding_up;
      part1 <= partial_row;
    end
  end

  always_comb begin
    r_ceil = {r1[31], r1[31:FRAC_BITS]} + 17'(|r1[FRAC_BITS-1:0]);
    fl = {l1[31:FRAC_BITS], {FRAC_BITS{1'b0}}};
    fr = {r_ceil[COL_W-1:0], {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_l2 <= l1[31:FRAC_BITS];
      col_r2 <= r_ceil[COL_W-1:0];
      len2   <= r_ceil - {l1[31], l1[31:FRAC_BITS]};
      a2     <= fl + ONE - l1;
      b2     <= r1 - fr + ONE;
      alpha2 <= sar((fr - l1) + (fr - r1), 1);
      row2   <= row1;
      rh2    <= rh1;
      dy2    <= dy1;
      neg2   <= neg1;
      part2  <= part1;
    end
  end

  assign mids3 = 16'(len2 - 17'd3);

  always_ff @(posedge clk) begin
    if (adv) begin
      col_l3 <= col_l2;
      col_r3 <= col_r2;
      len3   <= len2;
      a3     <= a2;
      sq_a3  <= mul_lo(sar(a2, TRI_SHIFT), sar(a2, TRI_SHIFT));
      sq_b3  <= mul_lo(sar(b2, TRI_SHIFT), sar(b2, TRI_SHIFT));
      fh3    <= mul_lo(sar(a2, LOW_SHIFT), {1'b0, dy2} >> LOW_SHIFT);
      run3   <= mul_lo({1'b0, dy2}, {16'd0, mids3});
      if (part2) begin
        alpha3 <= mul_lo(sar(alpha2, LOW_SHIFT), {15'd0, rh2} >> LOW_SHIFT);
      end else begin
        alpha3 <= alpha2;
      end
      row3   <= row2;
      rh3    <= rh2;
      dy3    <= dy2;
      neg3   <= neg2;
    end
  end

  assign dy_w3 = {1'b0, dy3};
  assign dy11  = dy_w3 >> TRI_SHIFT;

  always_ff @(posedge clk) begin
    if (adv) begin
      col_l4 <= col_l3;
      col_r4 <= col_r3;
      len4   <= len3;
      tri_a4 <= mul_lo(sq_a3, dy11);
      tri_b4 <= mul_lo(sq_b3, dy11);
      p4     <= mul_lo(sar(a3, LOW_SHIFT), sar(fh3, LOW_SHIFT));
      a1_4   <= fh3 + (dy_w3 >> 1);
      ar2_4  <= fh3 + (dy_w3 >> 1) + run3;
      alpha4 <= alpha3;
      row4   <= row3;
      rh4    <= rh3;
      dy4    <= dy3;
      neg4   <= neg3;
    end
  end

  // Final stage: pick the formula by span width and pack the results in
  // emission order, dropping the middle run when it is empty.
  logic [31:0] rh_w, dy_w4, a0, la, d3;
  logic [15:0] mids4;

  always_comb begin
    rh_w  = {15'd0, rh4};
    dy_w4 = {1'b0, dy4};
    a0    = sar(p4, 1);
    la    = rh_w - tri_b4;
    d3    = la - ar2_4;
    mids4 = 16'(len4 - 17'd3);

    set        = '0;
    set.neg    = neg4;
    set.row    = row4;
    set.run2   = 16'd1;
    set.column[0] = col_l4;
    set.column[1] = col_l4 + COL_W'(1);
    set.column[2] = col_l4 + COL_W'(2);
    set.column[3] = col_r4 - COL_W'(1);
    set.column[4] = col_r4;

    if (len4 == 17'd0) begin
      set.count    = CNT_W'(1);
      set.delta[0] = rh_w;
    end else if (len4 == 17'd1) begin
      set.count    = CNT_W'(2);
      set.delta[0] = alpha4;
      set.delta[1] = rh_w - alpha4;
    end else if (len4 == 17'd2) begin
      set.count    = CNT_W'(3);
      set.delta[0] = tri_a4;
      set.delta[1] = la - tri_a4;
      set.delta[2] = tri_b4;
    end else begin
      set.delta[0] = a0;
      set.delta[1] = a1_4 - a0;
      if (mids4 != 16'd0) begin
        set.count    = CNT_W'(5);
        set.run2     = mids4;
        set.delta[2] = dy_w4;
        set.delta[3] = d3;
        set.delta[4] = tri_b4;
      end else begin
        set.count     = CNT_W'(4);
        set.delta[2]  = d3;
        set.delta[3]  = tri_b4;
        set.column[2] = col_r4 - COL_W'(1);
        set.column[3] = col_r4;
      end
    end
  end

  assign set_valid = v4;

endmodule

[design/edge_row_coverage_deltas_unit.sv]
// Top level of the edge row coverage delta unit.
// Instantiates ercd_pipe and holds the result emitter; uses ercd_pkg.
//
// One edge piece is taken when start is high and busy is low. The piece
// gives one to five delta words, each on the result ports for a single
// cycle under strobe, in column order, with last on the final one; the
// words of one piece come in consecutive cycles. The first word passes the
// pipeline and emitter registers. A piece may be taken in every
// cycle, but the result port carries one word per cycle, so the sustained
// rate is one piece per as many cycles as it has words (up to five);
// busy rises when the emitter still holds words and a finished piece is
// waiting behind it. Results cannot be held off by the receiver.
module edge_row_coverage_deltas_unit
  import ercd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] row,
  input  logic [16:0] row_height,
  input  logic [31:0] start_x,
  input  logic [31:0] end_x,
  input  logic [30:0] slope_dy,
  input  logic        winding_up,
  input  logic        partial_row,
  output logic        strobe,
  output logic [15:0] column,
  output logic [15:0] out_row,
  output logic [15:0] run_length,
  output logic [31:0] delta,
  output logic        last
);

  logic             adv;
  logic             set_valid;
  delta_set_t       set;
  logic             load;
  logic             buf_valid;
  logic [CNT_W-1:0] k;
  delta_set_t       held;
  logic             cur_last;
  logic [31:0]      cur_delta;

  ercd_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .start      (start),
    .row        (row),
    .row_height (row_height),
    .start_x    (start_x),
    .end_x      (end_x),
    .slope_dy   (slope_dy),
    .winding_up (winding_up),
    .partial_row(partial_row),
    .set_valid  (set_valid),
    .set        (set)
  );

  assign cur_last  = buf_valid && (k == CNT_W'(held.count - CNT_W'(1)));
  assign load      = set_valid && (!buf_valid || cur_last);
  assign adv       = !set_valid || load;
  assign busy      = !adv;
  assign cur_delta = held.neg ? (32'd0 - held.delta[k]) : held.delta[k];

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      k         <= '0;
      strobe    <= 1'b0;
    end else begin
      strobe <= buf_valid;
      if (load) begin
        buf_valid <= 1'b1;
        k         <= '0;
      end else if (cur_last) begin
        buf_valid <= 1'b0;
      end else if (buf_valid) begin
        k <= k + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= set;
    end
    column     <= held.column[k];
    out_row    <= held.row;
    run_length <= (k == CNT_W'(2)) ? held.run2 : 16'd1;
    delta      <= cur_delta;
    last       <= cur_last;
  end

  a_busy_needs_word: assert property (@(posedge clk) disable iff (rst)
    busy |-> buf_valid)
    else $error("busy raised while the emitter holds no word");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (run_length != 16'd0))
    else $error("result word with an empty run");

  a_words_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside the words of one piece");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    load |-> (set.count >= CNT_W'(1) && set.count <= CNT_W'(NUM_OUT)))
    else $error("delta set loaded with a bad word count");

endmodule

[tb/delta_word_checker.sv]
`timescale 1ns / 100ps
// Checker for edge_row_coverage_deltas_unit: predicts the coverage delta words
// of every accepted edge piece and compares them with the result port.
// Depends only on the port widths of the unit; no package is needed.
module delta_word_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] row,
  input  logic [16:0] row_height,
  input  logic [31:0] start_x,
  input  logic [31:0] end_x,
  input  logic [30:0] slope_dy,
  input  logic        winding_up,
  input  logic        partial_row,
  input  logic        strobe,
  input  logic [15:0] column,
  input  logic [15:0] out_row,
  input  logic [15:0] run_length,
  input  logic [31:0] delta,
  input  logic        last,
  output int          fails,
  output int          pending
);

  localparam logic [31:0] UNIT = 32'h0001_0000;

  typedef struct packed {
    logic [15:0] column;
    logic [15:0] out_row;
    logic [15:0] run_length;
    logic [31:0] delta;
    logic        last;
  } delta_word_t;

  delta_word_t expected_words[$];

  function automatic logic [31:0] ashr(input logic [31:0] v, input int unsigned n);
    return $signed(v) >>> n;
  endfunction

  function automatic logic [31:0] low_product(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] p;
    p = ashr(a, 8) * ashr(b, 8);
    return p;
  endfunction

  function automatic logic [31:0] triangle_area(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    logic [31:0] p;
    s = ashr(a, 11);
    p = s * s * ashr(b, 11);
    return p;
  endfunction

  task automatic push_word(input int col, input logic [15:0] rw, input logic [15:0] run,
                           input logic [31:0] d, input logic neg, input logic is_last);
    delta_word_t w;
    w.column = 16'(col);
    w.out_row = rw;
    w.run_length = run;
    w.delta = neg ? 32'd0 - d : d;
    w.last = is_last;
    expected_words.push_back(w);
  endtask

  task automatic predict_piece(input logic [15:0] rw, input logic [16:0] rh_in,
                               input logic [31:0] sx, input logic [31:0] ex,
                               input logic [30:0] dy_in, input logic wu, input logic pr);
    logic [31:0] l, r, rh, dy, fl, fr, alpha, mid, a1, a2;
    logic [31:0] first, lastw, first_h, a0, mids, ar2, la;
    int lo_col, hi_col, span;
    logic neg;
    neg = !wu;
    rh = {15'd0, rh_in};
    dy = {1'b0, dy_in};
    if ($signed(sx) < $signed(ex)) begin
      l = sx;
      r = ex;
    end else begin
      l = ex;
      r = sx;
    end
    lo_col = $signed(ashr(l, 16));
    hi_col = $signed(ashr(r, 16));
    if (r[15:0] != 16'd0) begin
      hi_col = hi_col + 1;
    end
    span = hi_col - lo_col;
    fl = lo_col << 16;
    fr = hi_col << 16;
    if (span == 0) begin
      push_word(lo_col, rw, 16'd1, rh, neg, 1'b1);
    end else if (span == 1) begin
      alpha = ashr((fr - l) + (fr - r), 1);
      if (pr) begin
        alpha = low_product(alpha, rh);
      end
      push_word(lo_col, rw, 16'd1, alpha, neg, 1'b0);
      push_word(lo_col + 1, rw, 16'd1, rh - alpha, neg, 1'b1);
    end else if (span == 2) begin
      mid = fl + UNIT;
      a1 = triangle_area(mid - l, dy);
      a2 = rh - triangle_area(r - mid, dy);
      push_word(lo_col, rw, 16'd1, a1, neg, 1'b0);
      push_word(lo_col + 1, rw, 16'd1, a2 - a1, neg, 1'b0);
      push_word(lo_col + 2, rw, 16'd1, rh - a2, neg, 1'b1);
    end else begin
      first = UNIT + fl - l;
      lastw = r - (fr - UNIT);
      first_h = low_product(first, dy);
      a0 = ashr(low_product(first, first_h), 1);
      a1 = first_h + ashr(dy, 1);
      mids = span - 3;
      ar2 = a1 + dy * mids;
      la = rh - triangle_area(lastw, dy);
      push_word(lo_col, rw, 16'd1, a0, neg, 1'b0);
      push_word(lo_col + 1, rw, 16'd1, a1 - a0, neg, 1'b0);
      if (mids != 32'd0) begin
        push_word(lo_col + 2, rw, mids[15:0], dy, neg, 1'b0);
      end
      push_word(hi_col - 1, rw, 16'd1, la - ar2, neg, 1'b0);
      push_word(hi_col, rw, 16'd1, rh - la, neg, 1'b1);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t: %s got %h, expected %h", $realtime, what, got, want);
    fails = fails + 1;
  endtask

  always @(posedge clk) begin : watch
    delta_word_t want;
    if (rst) begin
      expected_words.delete();
    end else begin
      if (strobe) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, delta", delta, 32'd0);
        end else begin
          want = expected_words.pop_front();
          if (column !== want.column) begin
            report_mismatch("column", 32'(column), 32'(want.column));
          end
          if (out_row !== want.out_row) begin
            report_mismatch("out_row", 32'(out_row), 32'(want.out_row));
          end
          if (run_length !== want.run_length) begin
            report_mismatch("run_length", 32'(run_length), 32'(want.run_length));
          end
          if (delta !== want.delta) begin
            report_mismatch("delta", delta, want.delta);
          end
          if (last !== want.last) begin
            report_mismatch("last", 32'(last), 32'(want.last));
          end
        end
      end
      if (start && !busy) begin
        predict_piece(row, row_height, start_x, end_x, slope_dy, winding_up, partial_row);
      end
    end
    pending = expected_words.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Top of the testbench for edge_row_coverage_deltas_unit: drives edge pieces
// in directed and random phases and gives the verdict.
// Depends on edge_row_coverage_deltas_unit and delta_word_checker.
module tb;

  localparam int IDLE_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 63;
  localparam int END_PAUSE = 20;

  typedef struct {
    logic [15:0] row;
    logic [16:0] row_height;
    logic [31:0] start_x;
    logic [31:0] end_x;
    logic [30:0] slope_dy;
    logic        winding_up;
    logic        partial_row;
  } piece_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] row;
  logic [16:0] row_height;
  logic [31:0] start_x;
  logic [31:0] end_x;
  logic [30:0] slope_dy;
  logic        winding_up;
  logic        partial_row;
  logic        strobe;
  logic [15:0] column;
  logic [15:0] out_row;
  logic [15:0] run_length;
  logic [31:0] delta;
  logic        last;
  int          fails;
  int          pending;
  int          idle_cycles;

  edge_row_coverage_deltas_unit DUT (.*);

  delta_word_checker CHK (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("edge_row_coverage_deltas_unit: mismatch");
    $finish;
  end

  function automatic piece_t make_piece(input logic [15:0] rw, input logic [16:0] rh,
                                        input logic [31:0] sx, input logic [31:0] ex,
                                        input logic [30:0] dy, input logic wu,
                                        input logic pr);
    piece_t p;
    p.row = rw;
    p.row_height = rh;
    p.start_x = sx;
    p.end_x = ex;
    p.slope_dy = dy;
    p.winding_up = wu;
    p.partial_row = pr;
    return p;
  endfunction

  function automatic piece_t random_piece();
    piece_t p;
    int sel, span, base;
    int unsigned lead, trail;
    longint lo_x, hi_x;
    sel = $urandom_range(99);
    p.row = 16'($urandom);
    p.winding_up = 1'($urandom);
    p.partial_row = 1'($urandom);
    case ($urandom_range(3))
      0: p.row_height = 17'h10000;
      1: p.row_height = 17'($urandom);
      default: p.row_height = 17'($urandom_range(65536));
    endcase
    case ($urandom_range(3))
      0: p.slope_dy = 31'($urandom_range(262144));
      1: p.slope_dy = 31'($urandom >> $urandom_range(31));
      default: p.slope_dy = 31'($urandom);
    endcase
    if (sel < 10) begin
      p.start_x = $urandom;
      p.end_x = $urandom;
      return p;
    end
    if (sel < 20) span = 0;
    else if (sel < 35) span = 1;
    else if (sel < 50) span = 2;
    else if (sel < 65) span = 3;
    else if (sel < 75) span = 4;
    else if (sel < 95) span = $urandom_range(40, 5);
    else span = $urandom_range(65536, 41);
    case ($urandom_range(7))
      0: base = -32768;
      1: base = 32768 - span;
      2, 3: base = -32768 + int'($urandom_range(65536 - span));
      default: begin
        base = int'($urandom_range(200)) - 100;
        if (base > 32768 - span) begin
          base = 32768 - span;
        end
      end
    endcase
    lead = 0;
    trail = 0;
    if (span != 0) begin
      if ($urandom_range(3) != 0) lead = $urandom_range(65535);
      if ($urandom_range(3) != 0) trail = $urandom_range(65535);
      if (base + span == 32768 && trail == 0) trail = 1;
    end
    lo_x = longint'(base) * 65536 + lead;
    hi_x = longint'(base + span) * 65536 - trail;
    if (hi_x < lo_x) begin
      hi_x = lo_x;
    end
    if ($urandom_range(1) != 0) begin
      p.start_x = lo_x[31:0];
      p.end_x = hi_x[31:0];
    end else begin
      p.start_x = hi_x[31:0];
      p.end_x = lo_x[31:0];
    end
    return p;
  endfunction

  // Called at a falling edge; returns at the falling edge after the piece is taken.
  task automatic send_piece(input piece_t p, input int gap_pct);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    row <= p.row;
    row_height <= p.row_height;
    start_x <= p.start_x;
    end_x <= p.end_x;
    slope_dy <= p.slope_dy;
    winding_up <= p.winding_up;
    partial_row <= p.partial_row;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    piece_t directed[$];
    int gap_by_phase[4];
    rst = 1'b1;
    start = 1'b0;
    row = '0;
    row_height = '0;
    start_x = '0;
    end_x = '0;
    slope_dy = '0;
    winding_up = 1'b0;
    partial_row = 1'b0;
    gap_by_phase = '{0, 84, 0, 32};

    directed.push_back(make_piece(16'd0, 17'h10000, 32'h0, 32'h0, 31'h10000, 1'b1, 1'b0));
    directed.push_back(make_piece(16'h8000, 17'd0, 32'h00050000, 32'h00050000, 31'd0,
                                  1'b0, 1'b0));
    directed.push_back(make_piece(16'd5, 17'h08000, 32'h00018000, 32'h0001C000, 31'h20000,
                                  1'b1, 1'b1));
    directed.push_back(make_piece(16'h7FFF, 17'h10000, 32'h0001C000, 32'h00018000,
                                  31'h20000, 1'b0, 1'b0));
    directed.push_back(make_piece(16'd2, 17'h0C000, 32'h00024000, 32'h00024000, 31'h1000,
                                  1'b1, 1'b1));
    directed.push_back(make_piece(16'd1, 17'h10000, 32'h00038000, 32'h00044000, 31'h10000,
                                  1'b1, 1'b0));
    directed.push_back(make_piece(16'd1, 17'h10000, 32'h00044000, 32'h00038000, 31'h10000,
                                  1'b0, 1'b0));
    directed.push_back(make_piece(16'd3, 17'h10000, 32'h00008000, 32'h00028000, 31'h08000,
                                  1'b1, 1'b0));
    directed.push_back(make_piece(16'hFFFF, 17'h10000, 32'hFFFF4000, 32'h00024000,
                                  31'h18000, 1'b1, 1'b0));
    directed.push_back(make_piece(16'd9, 17'h1FFFF, 32'h80000000, 32'h7FFFFFFF,
                                  31'h7FFFFFFF, 1'b1, 1'b1));
    directed.push_back(make_piece(16'd10, 17'h10000, 32'h7FFF0001, 32'h7FFFFFFF, 31'h4000,
                                  1'b1, 1'b1));
    directed.push_back(make_piece(16'd11, 17'h10000, 32'h7FFF0000, 32'h7FFF0000, 31'd0,
                                  1'b1, 1'b0));
    directed.push_back(make_piece(16'd12, 17'h10000, 32'h80000000, 32'h80000000, 31'd0,
                                  1'b0, 1'b0));
    directed.push_back(make_piece(16'd13, 17'h10000, 32'h80018000, 32'h80000000, 31'h30000,
                                  1'b1, 1'b0));
    directed.push_back(make_piece(16'd14, 17'h1FFFF, 32'h00010000, 32'h00048000,
                                  31'h7FFFFFFF, 1'b1, 1'b0));
    directed.push_back(make_piece(16'd15, 17'h10000, 32'h00002000, 32'h00058000, 31'd0,
                                  1'b1, 1'b0));
    directed.push_back(make_piece(16'd16, 17'h06000, 32'hFFF80000, 32'hFFFF0001, 31'h0C000,
                                  1'b0, 1'b1));
    directed.push_back(make_piece(16'd17, 17'd0, 32'h00001000, 32'h0001F000, 31'h10000,
                                  1'b1, 1'b0));
    directed.push_back(make_piece(16'hFFFF, 17'h1FFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                  31'h7FFFFFFF, 1'b1, 1'b1));
    directed.push_back(make_piece(16'd19, 17'h10000, 32'h7FFD8000, 32'h7FFFFFFF, 31'h20000,
                                  1'b0, 1'b0));

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      send_piece(directed[i], 0);
    end
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_piece(random_piece(), gap_by_phase[phase]);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (END_PAUSE) @(negedge clk);

    if (fails == 0 && pending == 0) begin
      $display("edge_row_coverage_deltas_unit: match");
    end else begin
      $display("edge_row_coverage_deltas_unit: mismatch");
    end
    $finish;
  end

endmodule
